FILE: rtl/core/assert_macros.svh
// Assertion shorthands used by the RTL of the AIFF stream decoder.
// Expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held
`define AIFFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held
`define AIFFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/aiffd_pkg.sv
// Shared types and constants of the AIFF stream decoder.
// No dependencies; used by aiffd_rate and aiff_stream_pcm_decoder_unit.
package aiffd_pkg;

  // Chunk and format tags, big-endian ASCII
  localparam logic [31:0] TAG_FORM  = 32'h464F524D;
  localparam logic [31:0] TAG_AIFF  = 32'h41494646;
  localparam logic [31:0] TAG_AIFC  = 32'h41494643;
  localparam logic [31:0] TAG_COMM  = 32'h434F4D4D;
  localparam logic [31:0] TAG_SSND  = 32'h53534E44;
  localparam logic [31:0] TAG_SOWT  = 32'h736F7774;
  localparam logic [31:0] TAG_FL32L = 32'h666C3332;
  localparam logic [31:0] TAG_FL32U = 32'h464C3332;
  localparam logic [31:0] TAG_NONE  = 32'h4E4F4E45;

  // Extended-precision rate conversion
  localparam int          EXT_BIAS   = 16383;
  localparam int          MANT_SHIFT = 63;
  localparam logic [16:0] EXP_OFFSET = 17'(EXT_BIAS + MANT_SHIFT);
  localparam logic [23:0] RATE_MAX   = 24'hFFFFFF;

  // Reciprocal of three for the frame-count division
  localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

  // Configuration
  localparam logic [11:0] MAXSEC_RESET = 12'd60;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Result kinds
  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NOT_AIFF  = 4'd1;
  localparam logic [3:0] ST_MISSING   = 4'd2;
  localparam logic [3:0] ST_CHANNELS  = 4'd3;
  localparam logic [3:0] ST_COMPRESS  = 4'd4;
  localparam logic [3:0] ST_DEPTH     = 4'd5;
  localparam logic [3:0] ST_EMPTY     = 4'd6;
  localparam logic [3:0] ST_ORDER     = 4'd7;
  localparam logic [3:0] ST_TRUNCATED = 4'd8;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEAD,
    PH_CHDR,
    PH_COMM,
    PH_SSND,
    PH_SKIP,
    PH_PAD,
    PH_DEAD
  } phase_t;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [31:0] left;
    logic [31:0] right;
    logic        flt;
    logic        stereo;
    logic [23:0] rate;
    logic [31:0] total;
    logic [3:0]  status;
  } item_t;

  // Rounded rate and its presence flag
  typedef struct packed {
    logic        present;
    logic [23:0] hz;
  } rate_t;

endpackage

FILE: rtl/core/aiffd_rate.sv
// Converts an 80-bit extended-precision sample rate to a rounded 24-bit integer.
// Depends on aiffd_pkg.
module aiffd_rate (
  input  logic [79:0]      ext_val,
  output aiffd_pkg::rate_t rate
);
  import aiffd_pkg::*;

  logic               sgn;
  logic [14:0]        ex;
  logic [63:0]        mant;
  logic signed [16:0] sh;
  logic [16:0]        k;
  logic [4:0]         lsh;
  logic [63:0]        tmp;
  logic [64:0]        rnd;

  always_comb begin
    sgn  = ext_val[79];
    ex   = ext_val[78:64];
    mant = ext_val[63:0];
    sh   = $signed({2'b00, ex}) - $signed(EXP_OFFSET);
    k    = 17'(-sh);
    lsh  = sh[4:0];
    tmp  = '0;
    rnd  = '0;
    rate.present = !sgn && (mant != 64'd0);
    rate.hz      = '0;
    if (rate.present) begin
      if (sh >= 0) begin
        // left shift, saturate on overflow
        if (sh >= 17'sd24) begin
          rate.hz = RATE_MAX;
        end else if ((mant >> (5'd24 - lsh)) != 64'd0) begin
          rate.hz = RATE_MAX;
        end else begin
          tmp     = mant << lsh;
          rate.hz = tmp[23:0];
        end
      end else if (k <= 17'd64) begin
        // right shift, round half up
        tmp = mant >> (k - 17'd1);
        rnd = {2'b00, tmp[63:1]} + {64'd0, tmp[0]};
        rate.hz = (rnd > {41'd0, RATE_MAX}) ? RATE_MAX : rnd[23:0];
      end
    end
  end

endmodule

FILE: rtl/core/aiff_stream_pcm_decoder_unit.sv
// AIFF / AIFF-C stream decoder, one byte per ready cycle in, frames and status out.
// Depends on aiffd_pkg, aiffd_rate and assert_macros.svh.
//
// The decoder accepts one file byte per clock cycle while in_ready is high. Each
// byte goes through the header/chunk parser combinationally; a completed frame
// and, on the byte that carries end_of_file, a status item are written into a
// four-entry result queue. in_ready drops only while the queue has fewer than two
// free entries, so with the result side taking one item per cycle the input
// sustains one byte per cycle. The frame limit (min of declared frames, data
// bytes per frame size and max_seconds times rate) is computed in a two-stage
// pipeline after the SSND offset, always before the first frame can complete.
// Results are queued at the accepting edge. max_seconds sits at byte address 0.
`include "assert_macros.svh"

module aiff_stream_pcm_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  // byte input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_file,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_item_kind,
  output logic signed [31:0] out_left_sample,
  output logic signed [31:0] out_right_sample,
  output logic               out_is_float,
  output logic               out_stereo,
  output logic [23:0]        out_sample_rate,
  output logic [31:0]        out_frame_total,
  output logic [3:0]         out_status,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import aiffd_pkg::*;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [31:0] bif_r, bif_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic        aifc_r, aifc_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] decl_r, decl_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [79:0] ratex_r, ratex_nxt;
  logic [31:0] comp_r, comp_nxt;
  logic [31:0] offs_r, offs_nxt;
  logic [63:0] frame_r, frame_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [31:0] frames_r, frames_nxt;
  logic [31:0] limit_r, limit_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [3:0]  err_r, err_nxt;
  logic [11:0] maxsec_r;

  // limit pipeline
  logic        v0_r, v1_r;
  logic [31:0] lb_body_r, lb_decl_r, q_r, qd_r;
  logic [3:0]  lb_n_r;
  logic [11:0] lb_sec_r;
  logic [23:0] lb_rate_r;
  logic [35:0] cap_r;

  // result queue
  item_t                fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_r, rp_r;
  logic [FIFO_AW:0]     cnt_r;

  logic        in_acc, pop, kill, start_lim, emit;
  logic [1:0]  push_n;
  rate_t       rate_q;
  logic [2:0]  bps;
  logic [3:0]  nbytes;
  logic [31:0] b;
  logic [32:0] off_end;
  logic [31:0] body;
  logic        flt, sowt, reached;
  logic [63:0] full, aligned;
  logic [3:0]  rem;
  logic [7:0]  byt [8];
  logic [31:0] lw, rw;
  logic [2:0]  pos;
  logic [3:0]  st;
  logic [3:0]  ri;
  item_t       p0, p1;
  logic [31:0] mul_in;
  logic [63:0] prod;
  logic [31:0] m1;

  assign in_acc  = in_valid && in_ready;
  assign kill    = in_acc && in_end_of_file;
  assign pop     = out_valid && out_ready;
  assign in_ready = (cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {20'd0, maxsec_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxsec_r <= MAXSEC_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      maxsec_r <= pwdata[11:0];
    end
  end

  // rate bytes of COMM
  always_comb begin
    ratex_nxt = ratex_r;
    ri = 4'(bif_r[4:0] - 5'd8);
    if (phase_r == PH_COMM && bif_r >= 32'd8 && bif_r < 32'd18) begin
      for (int i = 0; i < 10; i++) begin
        if (ri == 4'(i)) ratex_nxt[8*(9-i) +: 8] = in_data_byte;
      end
    end
  end

  aiffd_rate u_rate (
    .ext_val (ratex_nxt),
    .rate    (rate_q)
  );

  // frame geometry and sample extraction
  always_comb begin
    bps     = depth_r[5:3];
    nbytes  = (chan_r == 16'd2) ? {bps, 1'b0} : {1'b0, bps};
    flt     = (comp_r == TAG_FL32L) || (comp_r == TAG_FL32U);
    sowt    = (comp_r == TAG_SOWT);
    reached = (frames_r >= limit_r);
    full    = {frame_r[55:0], in_data_byte};
    rem     = 4'd8 - nbytes;
    aligned = full << {rem[2:0], 3'b000};
    for (int p = 0; p < 8; p++) byt[p] = aligned[63-8*p -: 8];
    lw  = '0;
    rw  = '0;
    pos = '0;
    for (int k2 = 0; k2 < 4; k2++) begin
      if (3'(k2) < bps) begin
        pos = sowt ? 3'(bps - 3'd1 - 3'(k2)) : 3'(k2);
        lw[31-8*k2 -: 8] = byt[pos];
        pos = sowt ? 3'(bps + bps - 3'd1 - 3'(k2)) : 3'(bps + 3'(k2));
        rw[31-8*k2 -: 8] = byt[pos];
      end
    end
    if (chan_r != 16'd2) rw = '0;
  end

  // next state of the parser
  always_comb begin
    phase_nxt  = phase_r;
    bif_nxt    = bif_r;
    len_nxt    = len_r;
    tag_nxt    = tag_r;
    aifc_nxt   = aifc_r;
    chan_nxt   = chan_r;
    decl_nxt   = decl_r;
    depth_nxt  = depth_r;
    comp_nxt   = comp_r;
    offs_nxt   = offs_r;
    frame_nxt  = frame_r;
    fill_nxt   = fill_r;
    frames_nxt = frames_r;
    limit_nxt  = limit_r;
    seen_nxt   = seen_r;
    err_nxt    = err_r;
    emit       = 1'b0;
    start_lim  = 1'b0;
    b          = bif_r;
    off_end    = '0;
    body       = '0;
    case (phase_r)
      PH_HEAD: begin
        tag_nxt = {tag_r[23:0], in_data_byte};
        bif_nxt = b + 32'd1;
        if (b == 32'd3 && tag_nxt != TAG_FORM) begin
          err_nxt   = ST_NOT_AIFF;
          phase_nxt = PH_DEAD;
        end else if (b == 32'd11) begin
          if (tag_nxt == TAG_AIFC) aifc_nxt = 1'b1;
          if (tag_nxt == TAG_AIFC || tag_nxt == TAG_AIFF) begin
            phase_nxt = PH_CHDR;
            bif_nxt   = '0;
          end else begin
            err_nxt   = ST_NOT_AIFF;
            phase_nxt = PH_DEAD;
          end
        end
      end
      PH_CHDR: begin
        if (b < 32'd4) tag_nxt = {tag_r[23:0], in_data_byte};
        else len_nxt = {len_r[23:0], in_data_byte};
        bif_nxt = b + 32'd1;
        if (b == 32'd7) begin
          // open the chunk
          bif_nxt = '0;
          if (tag_nxt == TAG_COMM && len_nxt >= 32'd18 && !seen_r[1]) begin
            phase_nxt   = PH_COMM;
            seen_nxt[0] = 1'b1;
          end else if (tag_nxt == TAG_SSND && len_nxt >= 32'd8 && !seen_r[1]) begin
            phase_nxt = PH_SSND;
            offs_nxt  = '0;
            fill_nxt  = '0;
            frame_nxt = '0;
          end else begin
            phase_nxt = PH_SKIP;
          end
          if (len_nxt == 32'd0) phase_nxt = PH_CHDR;
        end
      end
      PH_PAD: begin
        phase_nxt = PH_CHDR;
        bif_nxt   = '0;
      end
      PH_COMM, PH_SSND, PH_SKIP: begin
        if (phase_r == PH_COMM) begin
          if (b < 32'd2) chan_nxt = {chan_r[7:0], in_data_byte};
          else if (b < 32'd6) decl_nxt = {decl_r[23:0], in_data_byte};
          else if (b < 32'd8) depth_nxt = {depth_r[7:0], in_data_byte};
          else if (b >= 32'd18 && b < 32'd22 && aifc_r && len_r >= 32'd22)
            comp_nxt = {comp_r[23:0], in_data_byte};
        end else if (phase_r == PH_SSND) begin
          if (b < 32'd4) begin
            offs_nxt = {offs_r[23:0], in_data_byte};
            if (b == 32'd3) begin
              // check the format once the offset is known
              off_end = {1'b0, offs_nxt} + 33'd8;
              body    = len_r - 32'd8 - offs_nxt;
              if (off_end > {1'b0, len_r}) begin
                phase_nxt = PH_SKIP;
              end else if (!seen_r[0]) begin
                err_nxt = ST_ORDER; phase_nxt = PH_DEAD;
              end else if (chan_r == 16'd0 || !rate_q.present) begin
                err_nxt = ST_MISSING; phase_nxt = PH_DEAD;
              end else if (chan_r > 16'd2) begin
                err_nxt = ST_CHANNELS; phase_nxt = PH_DEAD;
              end else if (!flt && !sowt && comp_r != TAG_NONE) begin
                err_nxt = ST_COMPRESS; phase_nxt = PH_DEAD;
              end else if (flt ? (depth_r != 16'd32)
                               : !(depth_r == 16'd8 || depth_r == 16'd16 ||
                                   depth_r == 16'd24 || depth_r == 16'd32)) begin
                err_nxt = ST_DEPTH; phase_nxt = PH_DEAD;
              end else if (decl_r == 32'd0 || body < {28'd0, nbytes} ||
                           rate_q.hz == 24'd0 || maxsec_r == 12'd0) begin
                err_nxt = ST_EMPTY; phase_nxt = PH_DEAD;
              end else begin
                seen_nxt[1] = 1'b1;
                limit_nxt   = '1;
                start_lim   = 1'b1;
              end
            end
          end else if (!({1'b0, b} < {1'b0, offs_r} + 33'd8) && !reached) begin
            // collect sample bytes
            frame_nxt = full;
            fill_nxt  = fill_r + 4'd1;
            if (fill_nxt == nbytes) begin
              emit       = 1'b1;
              fill_nxt   = '0;
              frame_nxt  = '0;
              frames_nxt = frames_r + 32'd1;
            end
          end
        end
        if (phase_nxt != PH_DEAD) begin
          bif_nxt = b + 32'd1;
          if (bif_nxt == len_r) begin
            bif_nxt   = '0;
            phase_nxt = len_r[0] ? PH_PAD : PH_CHDR;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result items
  always_comb begin
    st = err_nxt;
    if (st == ST_OK) begin
      if (phase_nxt == PH_HEAD) st = ST_NOT_AIFF;
      else if (phase_nxt == PH_COMM || phase_nxt == PH_SSND || phase_nxt == PH_SKIP)
        st = ST_TRUNCATED;
      else if (!seen_nxt[1]) st = ST_MISSING;
    end
    p1.kind   = KIND_STATUS;
    p1.left   = '0;
    p1.right  = '0;
    p1.flt    = (comp_nxt == TAG_FL32L) || (comp_nxt == TAG_FL32U);
    p1.stereo = (chan_nxt == 16'd2);
    p1.rate   = rate_q.hz;
    p1.total  = frames_nxt;
    p1.status = st;
    p0        = p1;
    if (emit) begin
      p0.kind   = KIND_FRAME;
      p0.left   = lw;
      p0.right  = rw;
      p0.status = ST_OK;
    end
    push_n = in_acc ? ({1'b0, emit} + {1'b0, in_end_of_file}) : 2'd0;
  end

  // parser registers; end of file returns to the reset state
  always_ff @(posedge clk) begin
    if (!rst_n || kill) begin
      phase_r  <= PH_HEAD;
      bif_r    <= '0;
      len_r    <= '0;
      tag_r    <= '0;
      aifc_r   <= 1'b0;
      chan_r   <= '0;
      decl_r   <= '0;
      depth_r  <= '0;
      ratex_r  <= '0;
      comp_r   <= TAG_NONE;
      offs_r   <= '0;
      frame_r  <= '0;
      fill_r   <= '0;
      frames_r <= '0;
      limit_r  <= '0;
      seen_r   <= '0;
      err_r    <= '0;
    end else begin
      if (in_acc) begin
        phase_r  <= phase_nxt;
        bif_r    <= bif_nxt;
        len_r    <= len_nxt;
        tag_r    <= tag_nxt;
        aifc_r   <= aifc_nxt;
        chan_r   <= chan_nxt;
        decl_r   <= decl_nxt;
        depth_r  <= depth_nxt;
        ratex_r  <= ratex_nxt;
        comp_r   <= comp_nxt;
        offs_r   <= offs_nxt;
        frame_r  <= frame_nxt;
        fill_r   <= fill_nxt;
        frames_r <= frames_nxt;
        seen_r   <= seen_nxt;
        err_r    <= err_nxt;
      end
      // settle the frame limit, else follow the parser
      if (v1_r) begin
        limit_r <= ({4'd0, m1} < cap_r) ? m1 : cap_r[31:0];
      end else if (in_acc) begin
        limit_r <= limit_nxt;
      end
    end
  end

  // limit pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= in_acc && start_lim && !in_end_of_file;
      v1_r <= v0_r && !kill;
    end
  end

  // limit pipeline data: divide by frame size, multiply seconds by rate
  always_comb begin
    mul_in = (lb_n_r == 4'd6) ? {1'b0, lb_body_r[31:1]} : lb_body_r;
    prod   = {32'd0, mul_in} * {32'd0, RECIP3};
    m1     = (q_r < qd_r) ? q_r : qd_r;
  end

  always_ff @(posedge clk) begin
    if (in_acc && start_lim) begin
      lb_body_r <= body;
      lb_n_r    <= nbytes;
      lb_decl_r <= decl_r;
      lb_sec_r  <= maxsec_r;
      lb_rate_r <= rate_q.hz;
    end
    case (lb_n_r)
      4'd2:       q_r <= {1'b0, lb_body_r[31:1]};
      4'd3, 4'd6: q_r <= 32'(prod >> 33);
      4'd4:       q_r <= {2'b00, lb_body_r[31:2]};
      4'd8:       q_r <= {3'b000, lb_body_r[31:3]};
      default:    q_r <= lb_body_r;
    endcase
    qd_r  <= lb_decl_r;
    cap_r <= {24'd0, lb_sec_r} * {12'd0, lb_rate_r};
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + FIFO_AW'(push_n);
      rp_r  <= rp_r + FIFO_AW'(pop);
      cnt_r <= cnt_r + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(pop);
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) fifo_r[wp_r] <= p0;
    if (push_n == 2'd2) fifo_r[wp_r + FIFO_AW'(1)] <= p1;
  end

  // drive the result port from the queue head
  assign out_valid        = (cnt_r != '0);
  assign out_item_kind    = fifo_r[rp_r].kind;
  assign out_left_sample  = fifo_r[rp_r].left;
  assign out_right_sample = fifo_r[rp_r].right;
  assign out_is_float     = fifo_r[rp_r].flt;
  assign out_stereo       = fifo_r[rp_r].stereo;
  assign out_sample_rate  = fifo_r[rp_r].rate;
  assign out_frame_total  = fifo_r[rp_r].total;
  assign out_status       = fifo_r[rp_r].status;

  `AIFFD_ASSERT_IMP(a_queue_bound, 1'b1, cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH), "queue overrun")
  `AIFFD_ASSERT_NXT(a_eof_clears, kill, phase_r == PH_HEAD && seen_r == 2'b00, "eof left state")
  `AIFFD_ASSERT_IMP(a_frame_status, out_valid && !out_item_kind, out_status == ST_OK, "bad status")
  `AIFFD_ASSERT_IMP(a_frame_cap, seen_r[1] && !v0_r && !v1_r, frames_r <= limit_r, "past limit")

endmodule

FILE: tb/testbench.sv
// Self-checking bench for the AIFF / AIFF-C stream decoder: byte files in, frames and status out.
// Depends on aiffd_pkg and aiff_stream_pcm_decoder_unit; a built-in parser model predicts each result.
`timescale 1ns / 1ps

module testbench;
  import aiffd_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_data_byte;
  logic               in_end_of_file;
  logic               out_valid;
  logic               out_ready;
  logic               out_item_kind;
  logic signed [31:0] out_left_sample;
  logic signed [31:0] out_right_sample;
  logic               out_is_float;
  logic               out_stereo;
  logic [23:0]        out_sample_rate;
  logic [31:0]        out_frame_total;
  logic [3:0]         out_status;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  localparam logic [2:0] ADDR_MAX_SECONDS = 3'd0;
  localparam int         STALL_LIMIT      = 5000;
  localparam int         LONG_HOLD        = 300;

  aiff_stream_pcm_decoder_unit DUT (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Parser model state
  phase_t      ph;
  logic [31:0] fld_idx;
  logic [31:0] chk_len;
  logic [31:0] chk_tag;
  logic        aifc_file;
  logic [15:0] num_chans;
  logic [31:0] decl_frames;
  logic [15:0] depth_bits;
  logic [7:0]  ext_rate [10];
  logic [31:0] comp_tag;
  logic [31:0] data_off;
  logic [63:0] frame_buf;
  logic [31:0] frame_fill;
  logic [31:0] frames_out;
  logic [63:0] frame_cap;
  logic [1:0]  seen;
  logic [3:0]  err_code;
  logic [11:0] max_secs;

  item_t expected_items [$];
  int    mismatches = 0;
  int    tx_idle;
  int    rx_idle;
  int    hold_left;
  logic  hold_taken;
  logic  long_hold_req = 1'b0;
  int    stall_cycles;
  logic [7:0] file_bytes [$];

  task automatic clear_parser();
    ph = PH_HEAD;
    fld_idx = '0; chk_len = '0; chk_tag = '0; aifc_file = 1'b0;
    num_chans = '0; decl_frames = '0; depth_bits = '0;
    for (int i = 0; i < 10; i++) ext_rate[i] = '0;
    comp_tag = TAG_NONE; data_off = '0; frame_buf = '0; frame_fill = '0;
    frames_out = '0; frame_cap = '0; seen = '0; err_code = ST_OK;
  endtask

  function automatic logic [63:0] rate_mant();
    logic [63:0] m;
    m = '0;
    for (int i = 2; i < 10; i++) m = {m[55:0], ext_rate[i]};
    return m;
  endfunction

  function automatic bit rate_valid();
    return !ext_rate[0][7] && rate_mant() != 0;
  endfunction

  // Round the 80-bit extended rate half up, saturating to 24 bits
  function automatic logic [23:0] rate_hz();
    logic [63:0] m;
    logic [63:0] v;
    int          e;
    int          s;
    int          k;
    m = rate_mant();
    e = {ext_rate[0][6:0], ext_rate[1]};
    s = e - EXT_BIAS - MANT_SHIFT;
    if (!rate_valid()) return '0;
    if (s >= 0) begin
      if (s >= 24 || m > (64'(RATE_MAX) >> s)) return RATE_MAX;
      return 24'(m << s);
    end
    k = -s;
    if (k > 64) v = '0;
    else if (k == 64) v = m >> 63;
    else v = (m >> k) + ((m >> (k - 1)) & 64'd1);
    return (v > 64'(RATE_MAX)) ? RATE_MAX : 24'(v);
  endfunction

  function automatic bit float_fmt();
    return comp_tag == TAG_FL32L || comp_tag == TAG_FL32U;
  endfunction

  function automatic item_t make_item(logic kind, logic [31:0] l, logic [31:0] r,
                                      logic [3:0] st);
    item_t it;
    it.kind = kind; it.left = l; it.right = r;
    it.flt = float_fmt(); it.stereo = (num_chans == 16'd2);
    it.rate = rate_hz(); it.total = frames_out; it.status = st;
    return it;
  endfunction

  task automatic enter_error(logic [3:0] code);
    err_code = code;
    ph = PH_DEAD;
  endtask

  task automatic close_chunk();
    fld_idx = '0;
    ph = chk_len[0] ? PH_PAD : PH_CHDR;
  endtask

  task automatic open_chunk();
    fld_idx = '0;
    if (chk_tag == TAG_COMM && chk_len >= 18 && !seen[1]) begin
      ph = PH_COMM;
      seen[0] = 1'b1;
    end else if (chk_tag == TAG_SSND && chk_len >= 8 && !seen[1]) begin
      ph = PH_SSND;
      data_off = '0; frame_fill = '0; frame_buf = '0;
    end else begin
      ph = PH_SKIP;
    end
    if (chk_len == 0) close_chunk();
  endtask

  // Check the format once the sound-data offset is known and set the frame cap
  task automatic check_format();
    logic [63:0] fb;
    logic [63:0] frames;
    logic [63:0] cap;
    if (64'(data_off) + 64'd8 > 64'(chk_len)) begin
      ph = PH_SKIP;
      return;
    end
    if (!seen[0]) begin enter_error(ST_ORDER); return; end
    if (num_chans == 0 || !rate_valid()) begin enter_error(ST_MISSING); return; end
    if (num_chans > 2) begin enter_error(ST_CHANNELS); return; end
    if (!float_fmt() && comp_tag != TAG_SOWT && comp_tag != TAG_NONE) begin
      enter_error(ST_COMPRESS);
      return;
    end
    if (float_fmt() ? depth_bits != 32 :
        !(depth_bits == 8 || depth_bits == 16 || depth_bits == 24 || depth_bits == 32)) begin
      enter_error(ST_DEPTH);
      return;
    end
    fb = 64'(depth_bits / 8) * 64'(num_chans);
    frames = (64'(chk_len) - 64'd8 - 64'(data_off)) / fb;
    cap = 64'(max_secs) * 64'(rate_hz());
    if (frames > 64'(decl_frames)) frames = 64'(decl_frames);
    if (frames > cap) frames = cap;
    if (frames == 0) begin enter_error(ST_EMPTY); return; end
    frame_cap = frames;
    seen[1] = 1'b1;
  endtask

  function automatic logic [31:0] pick_sample(int c, int bps, int n, bit swap);
    logic [31:0] w;
    int          pos;
    w = '0;
    for (int k = 0; k < bps; k++) begin
      pos = c * bps + (swap ? bps - 1 - k : k);
      w = {w[23:0], 8'(frame_buf >> (8 * (n - 1 - pos)))};
    end
    return w << (32 - 8 * bps);
  endfunction

  task automatic sound_byte(logic [31:0] b, logic [7:0] v);
    int          bps;
    int          n;
    bit          swap;
    logic [31:0] l;
    logic [31:0] r;
    if (b < 4) begin
      data_off = {data_off[23:0], v};
      if (b == 3) check_format();
      return;
    end
    if (64'(b) < 64'(data_off) + 64'd8 || 64'(frames_out) >= frame_cap) return;
    bps = depth_bits / 8;
    n = bps * num_chans;
    frame_buf = {frame_buf[55:0], v};
    frame_fill++;
    if (frame_fill < n) return;
    swap = (comp_tag == TAG_SOWT);
    l = pick_sample(0, bps, n, swap);
    r = (num_chans == 2) ? pick_sample(1, bps, n, swap) : '0;
    frame_fill = '0;
    frame_buf = '0;
    frames_out++;
    expected_items.push_back(make_item(KIND_FRAME, l, r, ST_OK));
  endtask

  // Advance the parser by one accepted byte and queue what it produces
  task automatic predict_byte(logic [7:0] v, logic eof);
    logic [31:0] b;
    logic [3:0]  st;
    b = fld_idx;
    case (ph)
      PH_HEAD: begin
        chk_tag = {chk_tag[23:0], v};
        fld_idx = b + 1;
        if (b == 3 && chk_tag != TAG_FORM) enter_error(ST_NOT_AIFF);
        else if (b == 11) begin
          if (chk_tag == TAG_AIFC) aifc_file = 1'b1;
          if (chk_tag == TAG_AIFC || chk_tag == TAG_AIFF) begin
            ph = PH_CHDR;
            fld_idx = '0;
          end else enter_error(ST_NOT_AIFF);
        end
      end
      PH_CHDR: begin
        if (b < 4) chk_tag = {chk_tag[23:0], v};
        else chk_len = {chk_len[23:0], v};
        fld_idx = b + 1;
        if (b == 7) open_chunk();
      end
      PH_PAD: begin
        ph = PH_CHDR;
        fld_idx = '0;
      end
      PH_COMM, PH_SSND, PH_SKIP: begin
        if (ph == PH_COMM) begin
          if (b < 2) num_chans = {num_chans[7:0], v};
          else if (b < 6) decl_frames = {decl_frames[23:0], v};
          else if (b < 8) depth_bits = {depth_bits[7:0], v};
          else if (b < 18) ext_rate[b - 8] = v;
          else if (b < 22 && aifc_file && chk_len >= 22) comp_tag = {comp_tag[23:0], v};
        end else if (ph == PH_SSND) sound_byte(b, v);
        if (ph != PH_DEAD) begin
          fld_idx = b + 1;
          if (fld_idx == chk_len) close_chunk();
        end
      end
      default: ;
    endcase
    if (eof) begin
      st = err_code;
      if (st == ST_OK) begin
        if (ph == PH_HEAD) st = ST_NOT_AIFF;
        else if (ph == PH_COMM || ph == PH_SSND || ph == PH_SKIP) st = ST_TRUNCATED;
        else if (!seen[1]) st = ST_MISSING;
      end
      expected_items.push_back(make_item(KIND_STATUS, '0, '0, st));
      clear_parser();
    end
  endtask

  // Offer one byte, hold it until the transfer, then predict
  task automatic send_byte(logic [7:0] v, logic eof);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= v;
    in_end_of_file <= eof;
    do @(posedge clk); while (!in_ready);
    predict_byte(v, eof);
  endtask

  task automatic write_max_seconds(logic [11:0] secs);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_MAX_SECONDS; pwdata <= 32'(secs);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    max_secs = secs;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (expected_items.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8 * i +: 8]);
  endtask

  function automatic logic [7:0] data_val();
    case ($urandom_range(9))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_chunk(logic [31:0] tag, logic [31:0] len, logic [7:0] body [$]);
    add_word(tag);
    add_word(len);
    for (int i = 0; i < len; i++) file_bytes.push_back(i < body.size() ? body[i] : data_val());
    if (len[0]) file_bytes.push_back(8'($urandom));
  endtask

  // Build one file: mostly well-formed with random fields, some broken or noise
  task automatic build_file();
    int          sel;
    int          r;
    int          p;
    int          bps;
    int          chg;
    int          nfr;
    int          off;
    int          fbytes;
    logic        aifc;
    logic [15:0] chans;
    logic [15:0] depth;
    logic [31:0] comp;
    logic [31:0] dfr;
    logic [15:0] sexp;
    logic [63:0] mant;
    logic [31:0] comm_len;
    logic [31:0] ssnd_len;
    logic [7:0]  comm_body [$];
    logic [7:0]  ssnd_body [$];
    logic [7:0]  xtra [$];
    file_bytes.delete();
    sel = $urandom_range(99);
    if (sel < 5) begin
      repeat ($urandom_range(1, 16)) file_bytes.push_back(8'($urandom));
      return;
    end
    add_word(TAG_FORM);
    add_word($urandom);
    aifc = $urandom_range(1);
    add_word(sel < 9 ? 32'($urandom) : (aifc ? TAG_AIFC : TAG_AIFF));
    chans = ($urandom_range(99) < 90) ? 16'($urandom_range(1, 2)) :
            ($urandom_range(1) ? 16'd0 : 16'($urandom_range(3, 65535)));
    comp = TAG_NONE;
    if (aifc)
      case ($urandom_range(9))
        3, 4:    comp = TAG_SOWT;
        5, 6:    comp = TAG_FL32L;
        7, 8:    comp = TAG_FL32U;
        9:       comp = $urandom;
        default: comp = TAG_NONE;
      endcase
    if ((comp == TAG_FL32L || comp == TAG_FL32U) && $urandom_range(9) < 8) depth = 16'd32;
    else if ($urandom_range(99) < 85) depth = 16'(8 * $urandom_range(1, 4));
    else depth = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    dfr = ($urandom_range(99) < 85) ? 32'($urandom_range(1, 12)) :
          ($urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF);
    // Sample rate as 80-bit extended
    sel = $urandom_range(99);
    r = (sel < 10) ? $urandom_range(1, 10) : $urandom_range(11, 96000);
    p = 0;
    for (int i = 0; i < 32; i++) if ((r >> i) & 1) p = i;
    sexp = 16'(EXT_BIAS + p);
    mant = 64'(r) << (63 - p);
    if ($urandom_range(1)) mant = mant | ({$urandom, $urandom} & ((64'd1 << (63 - p)) - 1));
    if (sel >= 85)
      case ($urandom_range(4))
        0: sexp[15] = 1'b1;
        1: mant = '0;
        2: sexp = 16'(EXT_BIAS + $urandom_range(24, 70));
        3: sexp = 16'(EXT_BIAS - $urandom_range(1, 70));
        default: begin sexp = 16'($urandom); mant = {$urandom, $urandom}; end
      endcase
    comm_body = {chans[15:8], chans[7:0], dfr[31:24], dfr[23:16], dfr[15:8], dfr[7:0],
                 depth[15:8], depth[7:0], sexp[15:8], sexp[7:0]};
    for (int i = 7; i >= 0; i--) comm_body.push_back(mant[8 * i +: 8]);
    for (int i = 3; i >= 0; i--) comm_body.push_back(comp[8 * i +: 8]);
    comm_len = aifc ? 32'(22 + $urandom_range(0, 3)) : 32'(18 + $urandom_range(0, 1));
    if ($urandom_range(99) < 5) comm_len = $urandom_range(0, 17);
    // Sound data sized from the chosen format
    bps = depth / 8;
    if (bps < 1 || bps > 4) bps = 2;
    chg = (chans == 1 || chans == 2) ? int'(chans) : 1;
    fbytes = bps * chg;
    nfr = $urandom_range(0, 12);
    off = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
    ssnd_len = 32'(8 + off + nfr * fbytes);
    if ($urandom_range(3) == 0) ssnd_len += 32'($urandom_range(0, fbytes - 1));
    if ($urandom_range(99) < 4) ssnd_len = $urandom_range(0, 7);
    else if ($urandom_range(99) < 4) off = ssnd_len;
    ssnd_body = {8'(off >> 24), 8'(off >> 16), 8'(off >> 8), 8'(off)};
    repeat (4) ssnd_body.push_back(8'($urandom));
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(0, 5)) xtra.push_back(8'($urandom));
      add_chunk(32'h5854_5241, xtra.size(), xtra);
    end
    sel = $urandom_range(99);
    if (sel < 5) add_chunk(TAG_SSND, ssnd_len, ssnd_body);
    else if (sel < 10) begin
      add_chunk(TAG_SSND, ssnd_len, ssnd_body);
      add_chunk(TAG_COMM, comm_len, comm_body);
    end else begin
      add_chunk(TAG_COMM, comm_len, comm_body);
      add_chunk(TAG_SSND, ssnd_len, ssnd_body);
      if ($urandom_range(9) == 0) add_chunk(TAG_COMM, comm_len, comm_body);
    end
    if ($urandom_range(99) < 8) begin
      r = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > r) void'(file_bytes.pop_back());
    end
  endtask

  task automatic random_files(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      build_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
      sent += file_bytes.size();
    end
  endtask

  // Directed bytes: short and bad headers, then a header with no chunks
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       typed;
    logic [3:0] st;
  } drow_t;

  drow_t dir_rows [22] = '{
    '{8'h00, 1'b1, 1'b1, ST_NOT_AIFF}, '{8'hFF, 1'b1, 1'b1, ST_NOT_AIFF},
    '{8'h46, 1'b0, 1'b0, ST_OK}, '{8'h4F, 1'b0, 1'b0, ST_OK},
    '{8'h52, 1'b0, 1'b0, ST_OK}, '{8'h58, 1'b1, 1'b1, ST_NOT_AIFF},
    '{8'h46, 1'b0, 1'b0, ST_OK}, '{8'h4F, 1'b0, 1'b0, ST_OK},
    '{8'h52, 1'b0, 1'b0, ST_OK}, '{8'h4D, 1'b1, 1'b1, ST_NOT_AIFF},
    '{8'h46, 1'b0, 1'b0, ST_OK}, '{8'h4F, 1'b0, 1'b0, ST_OK},
    '{8'h52, 1'b0, 1'b0, ST_OK}, '{8'h4D, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h04, 1'b0, 1'b0, ST_OK},
    '{8'h41, 1'b0, 1'b0, ST_OK}, '{8'h49, 1'b0, 1'b0, ST_OK},
    '{8'h46, 1'b0, 1'b0, ST_OK}, '{8'h46, 1'b1, 1'b1, ST_MISSING}
  };

  // Main sequence
  initial begin
    item_t fixed;
    rst_n = 1'b0; in_valid = 1'b0; in_data_byte = '0; in_end_of_file = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    tx_idle = 22; rx_idle = 86;
    max_secs = MAXSEC_RESET;
    clear_parser();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_max_seconds(MAXSEC_RESET);
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].eof);
      if (dir_rows[i].typed) begin
        fixed = '0;
        fixed.kind = KIND_STATUS;
        fixed.status = dir_rows[i].st;
        expected_items[expected_items.size() - 1] = fixed;
      end
    end
    random_files(530);
    drain_results();
    write_max_seconds(12'd1);
    tx_idle = 86; rx_idle = 22;
    random_files(550);
    drain_results();
    write_max_seconds(12'd3600);
    tx_idle = 0; rx_idle = 0;
    long_hold_req = 1'b1;
    random_files(550);
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_items.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // Drive result-side back-pressure, with one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (long_hold_req && !hold_taken) begin
      out_ready  <= 1'b0;
      hold_left  <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    item_t got;
    item_t want;
    if (rst_n && out_valid && out_ready) begin
      got.kind = out_item_kind; got.left = out_left_sample; got.right = out_right_sample;
      got.flt = out_is_float; got.stereo = out_stereo; got.rate = out_sample_rate;
      got.total = out_frame_total; got.status = out_status;
      if (expected_items.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_items.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: kind %0d/%0d left %h/%h right %h/%h flt %0d/%0d st %0d/%0d rate %0d/%0d total %0d/%0d status %0d/%0d (exp/act)",
                     want.kind, got.kind, want.left, got.left, want.right, got.right,
                     want.flt, got.flt, want.stereo, got.stereo, want.rate, got.rate,
                     want.total, got.total, want.status, got.status);
        end
      end
    end
  end

  // Abort when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

FILE: aiff_stream_pcm_decoder_unit.f
+incdir+rtl/core
rtl/core/aiffd_pkg.sv
rtl/core/aiffd_rate.sv
rtl/core/aiff_stream_pcm_decoder_unit.sv
tb/testbench.sv
